// ----- rtl/idrm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// idrm_pkg: shared types and constants of the id range map table
// Table size, operation and status codes, entry and result layouts, and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package idrm_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int PASS_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [2:0] {
    OP_WRITE   = 3'd0,
    OP_XLATE   = 3'd1,
    OP_NS_FIND = 3'd2,
    OP_REUSE   = 3'd3,
    OP_FREE    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // lookup key and range selection for the compare
  typedef enum logic [1:0] {
    KEY_HOST_Q = 2'd0,
    KEY_NS_Q   = 2'd1,
    KEY_NS_F   = 2'd2
  } key_sel_t;

  // how the result register is loaded
  typedef enum logic [2:0] {
    RES_DONE     = 3'd0,
    RES_MISS     = 3'd1,
    RES_HOST_HIT = 3'd2,
    RES_NS_HIT   = 3'd3,
    RES_FREE     = 3'd4,
    RES_ALLOC    = 3'd5
  } res_sel_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] ns_base;
    logic [31:0] host_base;
    logic [31:0] span;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    status_t     status;
    logic [31:0] result_id;
    logic [3:0]  hit_slot;
    logic        kind;
    logic [31:0] ns_base;
    logic [31:0] host_base;
    logic [31:0] span;
  } result_t;

  typedef struct packed {
    logic     cap;
    logic     table_wr;
    logic     scan_start;
    logic     scan_run;
    key_sel_t key_sel;
    logic     free_init;
    logic     free_step;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic slot_ok;
    logic hit;
    logic miss_end;
    logic pass_last;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// ----- rtl/id_range_map_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// id_range_map_table: ordered table of user/group id range mappings
// Slot writes, host-to-namespace translation, namespace entry lookup,
// reuse-or-propose mapping and lowest free namespace id search.
// ----------------------------------------------------------------------------
// One request is handled at a time; every request gives exactly one result.
// Entries sit in a single-read-port RAM and are scanned in slot order at one
// entry per cycle. A slot write or an unknown op loads the result register
// when accepted; a lookup loads it at the first hit or after the last slot;
// the free-id search rescans from slot 0 after each covering range, up to
// TABLE_ENTRIES+1 passes, and needs a single pass when id 0 is free. A
// reuse-or-allocate miss runs the lookup and then the free-id search. Each
// result moves on to the output register once the output side is free. The
// output register lets a new request be accepted while the previous result
// waits for m_tready.
// Range ends are compared 33 bits wide; a free id of 2^32 or more reports
// status "no free id". Entries never written read as empty.
// ----------------------------------------------------------------------------
module id_range_map_table (
  input  wire logic         clk,
  input  wire logic         rst,
  // request stream
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [135:0] s_tdata,  // slot[3:0], slot_valid[4], ns_base[36:5],
                                      // host_base[68:37], span[100:69],
                                      // query_id[132:101], zero pad[135:133]
  input  wire logic [3:0]   s_tuser,  // op[2:0], id_kind[3]
  // result stream
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [135:0]      m_tdata,  // result_id[31:0], hit_slot[35:32],
                                      // out_ns_base[67:36], out_host_base[99:68],
                                      // out_span[131:100], zero pad[135:132]
  output logic [2:0]        m_tuser   // status[1:0], out_kind[2]
);
  import idrm_pkg::*;

  cmd_t    cmd;
  stat_t   stat;
  result_t res;
  logic    in_fire;
  op_t     in_op;

  assign in_fire = s_tvalid & s_tready;
  assign in_op   = op_t'(s_tuser[2:0]);

  // sequence the request
  idrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .in_op    (in_op),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // hold the table, compare ranges, build the result
  idrm_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_slot       (s_tdata[3:0]),
    .in_slot_valid (s_tdata[4]),
    .in_kind       (s_tuser[3]),
    .in_ns_base    (s_tdata[36:5]),
    .in_host_base  (s_tdata[68:37]),
    .in_span       (s_tdata[100:69]),
    .in_query_id   (s_tdata[132:101]),
    .out_valid     (m_tvalid),
    .out_res       (res),
    .out_ready     (m_tready)
  );

  // pack the result fields, lowest first
  assign m_tdata = {4'd0, res.span, res.host_base, res.ns_base, res.hit_slot,
                    res.result_id};
  assign m_tuser = {res.kind, res.status};

  // an accepted request takes the block out of the idle state, so it is not ready in the following cycle
  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_tready)
    else $error("request accepted while previous request still in progress");

  // the status code is one of the three defined values
  a_status_code : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[1:0] != 2'd3))
    else $error("undefined status code on result");

  // "no free id" carries no mapping
  a_full_is_empty : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[1:0] == ST_FULL)) |-> ((m_tdata == '0) && !m_tuser[2]))
    else $error("no-free-id result carries data");

  // the output register is only loaded when the output side can take it
  a_load_when_free : assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result overwritten before it was taken");

endmodule
`default_nettype wire

// ----- rtl/idrm_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// idrm_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module idrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/idrm_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// idrm_ctrl: operation sequencer
// Decode the request, run table scans and free-id passes, hand off results.
// ----------------------------------------------------------------------------
module idrm_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_fire,
  input  wire idrm_pkg::op_t   in_op,
  output logic                 in_ready,
  input  wire idrm_pkg::stat_t stat,
  output idrm_pkg::cmd_t       cmd
);
  import idrm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_FREE  = 5'b00100,
    S_FLOAD = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state, state_next;
  op_t    op_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q <= in_op;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.key_sel = KEY_HOST_Q;
    cmd.res_sel = RES_MISS;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.cap = 1'b1;
          case (in_op)
            OP_WRITE: begin
              cmd.table_wr = stat.slot_ok;
              cmd.res_load = 1'b1;
              cmd.res_sel  = stat.slot_ok ? RES_DONE : RES_MISS;
              state_next   = S_RESP;
            end
            OP_XLATE, OP_REUSE, OP_NS_FIND: begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
            OP_FREE: begin
              cmd.free_init  = 1'b1;
              cmd.scan_start = 1'b1;
              state_next     = S_FREE;
            end
            default: begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_MISS;
              state_next   = S_RESP;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        cmd.key_sel  = (op_q == OP_NS_FIND) ? KEY_NS_Q : KEY_HOST_Q;
        if (stat.hit) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = (op_q == OP_NS_FIND) ? RES_NS_HIT : RES_HOST_HIT;
          state_next   = S_RESP;
        end else if (stat.miss_end) begin
          if (op_q == OP_REUSE) begin
            cmd.free_init  = 1'b1;
            cmd.scan_start = 1'b1;
            state_next     = S_FREE;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_MISS;
            state_next   = S_RESP;
          end
        end
      end
      S_FREE: begin
        cmd.scan_run = 1'b1;
        cmd.key_sel  = KEY_NS_F;
        if (stat.hit) begin
          // advance the candidate past the covering range, rescan unless out of passes
          cmd.free_step = 1'b1;
          if (stat.pass_last) begin
            state_next = S_FLOAD;
          end else begin
            cmd.scan_start = 1'b1;
          end
        end else if (stat.miss_end) begin
          state_next = S_FLOAD;
        end
      end
      S_FLOAD: begin
        cmd.key_sel  = KEY_NS_F;
        cmd.res_load = 1'b1;
        cmd.res_sel  = (op_q == OP_REUSE) ? RES_ALLOC : RES_FREE;
        state_next   = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/idrm_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// idrm_dp: table storage, range compare and result registers
// Entry RAM with valid flops, one-entry-per-cycle scan, free-id candidate.
// ----------------------------------------------------------------------------
module idrm_dp (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire idrm_pkg::cmd_t   cmd,
  output idrm_pkg::stat_t       stat,
  input  wire logic [3:0]       in_slot,
  input  wire logic             in_slot_valid,
  input  wire logic             in_kind,
  input  wire logic [31:0]      in_ns_base,
  input  wire logic [31:0]      in_host_base,
  input  wire logic [31:0]      in_span,
  input  wire logic [31:0]      in_query_id,
  output logic                  out_valid,
  output idrm_pkg::result_t     out_res,
  input  wire logic             out_ready
);
  import idrm_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [TABLE_ENTRIES-1:0] valid;
  logic [IDX_W-1:0]         waddr;
  logic [IDX_W-1:0]         addr;
  logic [IDX_W-1:0]         cmp_idx;
  logic                     cmp_live;
  logic                     issued_all;
  logic [ENTRY_W-1:0]       rd_data;
  entry_t                   ent;
  entry_t                   wr_ent;

  logic                     q_kind;
  logic [31:0]              q_id;
  logic [32:0]              f;
  logic [PASS_W-1:0]        pass;

  logic [32:0]              key;
  logic [32:0]              lo;
  logic [32:0]              hi;
  logic [31:0]              base;
  logic                     match;
  result_t                  res;
  result_t                  res_next;

  assign waddr  = IDX_W'(in_slot);
  assign wr_ent = '{kind: in_kind, ns_base: in_ns_base, host_base: in_host_base,
                    span: in_span};

  idrm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.table_wr & in_slot_valid),
    .waddr (waddr),
    .wdata (wr_ent),
    .re    (cmd.scan_run),
    .raddr (addr),
    .rdata (rd_data)
  );

  assign ent = entry_t'(rd_data);

  // valid bits and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      cmp_live   <= 1'b0;
      issued_all <= 1'b0;
      addr       <= '0;
    end else begin
      if (cmd.table_wr) begin
        valid[waddr] <= in_slot_valid;
      end
      if (cmd.scan_start) begin
        addr       <= '0;
        cmp_live   <= 1'b0;
        issued_all <= 1'b0;
      end else if (cmd.scan_run) begin
        cmp_live <= ~issued_all;
        if (addr == LAST_IDX) begin
          issued_all <= 1'b1;
        end else begin
          addr <= addr + 1'b1;
        end
      end else begin
        cmp_live <= 1'b0;
      end
    end
  end

  // query capture and free-id candidate
  always_ff @(posedge clk) begin
    if (cmd.scan_run) begin
      cmp_idx <= addr;
    end
    if (cmd.cap) begin
      q_kind <= in_kind;
      q_id   <= in_query_id;
    end
    if (cmd.free_init) begin
      f    <= '0;
      pass <= '0;
    end else if (cmd.free_step) begin
      f    <= hi;
      pass <= pass + 1'b1;
    end
  end

  // range compare on the entry read last cycle
  always_comb begin
    base = (cmd.key_sel == KEY_HOST_Q) ? ent.host_base : ent.ns_base;
    case (cmd.key_sel)
      KEY_HOST_Q, KEY_NS_Q: key = {1'b0, q_id};
      KEY_NS_F:             key = f;
      default:              key = {1'b0, q_id};
    endcase
    lo    = {1'b0, base};
    hi    = {1'b0, base} + {1'b0, ent.span};
    match = cmp_live & valid[cmp_idx] & (ent.kind == q_kind) & (key >= lo) & (key < hi);
  end

  always_comb begin
    stat.slot_ok   = ({28'd0, in_slot} < 32'(TABLE_ENTRIES));
    stat.hit       = match;
    stat.miss_end  = cmp_live & ~match & (cmp_idx == LAST_IDX);
    stat.pass_last = (pass == PASS_W'(TABLE_ENTRIES));
    stat.out_free  = ~out_valid | out_ready;
  end

  always_comb begin
    res_next        = '0;
    res_next.status = ST_MISS;
    case (cmd.res_sel)
      RES_DONE: begin
        res_next.status = ST_OK;
      end
      RES_MISS: begin
        res_next.status = ST_MISS;
      end
      RES_HOST_HIT, RES_NS_HIT: begin
        res_next.status    = ST_OK;
        res_next.result_id = (cmd.res_sel == RES_HOST_HIT) ?
                             (q_id - ent.host_base + ent.ns_base) : 32'd0;
        res_next.hit_slot  = 4'(cmp_idx);
        res_next.kind      = ent.kind;
        res_next.ns_base   = ent.ns_base;
        res_next.host_base = ent.host_base;
        res_next.span      = ent.span;
      end
      RES_FREE: begin
        if (f[32]) begin
          res_next.status = ST_FULL;
        end else begin
          res_next.status    = ST_OK;
          res_next.result_id = f[31:0];
        end
      end
      RES_ALLOC: begin
        if (f[32]) begin
          res_next.status = ST_FULL;
        end else begin
          res_next.status    = ST_MISS;
          res_next.result_id = f[31:0];
          res_next.kind      = q_kind;
          res_next.ns_base   = f[31:0];
          res_next.host_base = q_id;
          res_next.span      = 32'd1;
        end
      end
      default: begin
        res_next.status = ST_MISS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res <= res_next;
    end
    if (cmd.out_load) begin
      out_res <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire
